>>> hdl/assert_macros.svh
// Assertion macros used by the checker of the receive deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is held.
`define T1_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, written as an overlapping implication.
`define T1_ASSERT_IMPL(lbl, ante, cons, msg) \
    `T1_ASSERT(lbl, ((ante) |-> (cons)), msg)

`endif

>>> hdl/t1rx_pkg.sv
// Shared types, constants and functions of the receive deframer and CRC_B checker.
package t1rx_pkg;

    localparam int MAX_COUNT   = 255;
    localparam int DCNT_W      = $clog2(MAX_COUNT + 3);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MIN_DECODED = 4;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PARITY = 2'd1,
        ST_CRC    = 2'd2,
        ST_SHORT  = 2'd3
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // One queue entry: what a single request leaves for the back end to emit.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        frame_end;
        logic        parity_bad;
        logic        too_few;
        logic [15:0] crc_rx;
        logic [7:0]  pcount;
    } t_entry;

    function automatic logic [15:0] crc_b_feed(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Payload bytes released so far: decoded bytes minus the two held back.
    function automatic logic [7:0] payload_count_of(input logic [DCNT_W-1:0] dc);
        logic [DCNT_W+7:0] p;
        p = (dc >= DCNT_W'(2)) ? {8'd0, dc} - (DCNT_W + 8)'(2) : '0;
        return (p > (DCNT_W + 8)'(255)) ? 8'hFF : p[7:0];
    endfunction

endpackage

>>> hdl/t1rx_ifs.sv
// Valid/ready channel interfaces for raw input bytes and result items.
interface t1rx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       frame_end;

    modport source (output valid, output raw_byte, output frame_end, input ready);
    modport sink   (input valid, input raw_byte, input frame_end, output ready);
endinterface

interface t1rx_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] data_byte;
    logic [1:0] frame_status;
    logic [7:0] payload_count;
    logic       last_of_run;

    modport source (output valid, output item_kind, output data_byte,
                    output frame_status, output payload_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input item_kind, input data_byte,
                    input frame_status, input payload_count, input last_of_run,
                    output ready);
endinterface

>>> hdl/type1_tag_rx_deframe_crc_check_unit.sv
// Top level of the tag receive deframer with parity and CRC_B check.
//
// i_in carries raw received bytes, least significant bit first, with
// frame_end on the last byte of a frame. o_out carries result items: a
// payload byte (item_kind 0) or the end-of-frame status (item_kind 1) with
// the payload count; last_of_run marks the final item caused by a request.
// The first two decoded bytes of a frame are held back, so payload leaves
// two decoded bytes late; the trailing two are checked as the CRC_B.
// One raw byte is taken per cycle while i_in.ready is high. A released byte
// passes the queue and the output register to o_out; the status item follows
// any payload byte of the same request, since the result stage emits one item
// per cycle while o_out.ready is high. The front end never waits on the
// result stage except through the four-entry queue: when o_out.ready
// stays low the output register holds, the queue fills, and only then does
// i_in.ready drop. Synchronous active-low reset clears the deframer state,
// the queue and the output valid, and presets the CRC register.
module type1_tag_rx_deframe_crc_check_unit
    import t1rx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    t1rx_in_if.sink     i_in,
    t1rx_out_if.source  o_out
);

    logic   q_push;
    logic   q_ready;
    logic   q_pop;
    logic   q_head_valid;
    t_entry q_entry;
    t_entry q_head;

    t1rx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_entry (q_entry)
    );

    t1rx_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_entry      (q_entry),
        .o_ready      (q_ready),
        .i_pop        (q_pop),
        .o_head       (q_head),
        .o_head_valid (q_head_valid)
    );

    t1rx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (q_head_valid),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

endmodule

>>> hdl/t1rx_front.sv
// Front end: bit unpacking, parity tracking and the two-byte CRC hold-back line.
module t1rx_front
    import t1rx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    t1rx_in_if.sink     i_in,
    input  logic        i_q_ready,
    output logic        o_q_push,
    output t_entry      o_q_entry
);

    logic [7:0]        r_buf,   n_buf;
    logic [2:0]        r_fill,  n_fill;
    logic              r_pos,   n_pos;
    logic [7:0]        r_h0,    n_h0;
    logic [7:0]        r_h1,    n_h1;
    logic [1:0]        r_hcnt,  n_hcnt;
    logic              r_pend,  n_pend;
    logic              r_pfail, n_pfail;
    logic [DCNT_W-1:0] r_dcnt,  n_dcnt;

    logic accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    always_comb begin
        logic [15:0]       b;
        logic [4:0]        f;
        logic              pos;
        logic              pend;
        logic              pfail;
        logic [DCNT_W-1:0] dc;
        logic [7:0]        h0;
        logic [7:0]        h1;
        logic [1:0]        hc;
        logic [7:0]        dec;
        logic [7:0]        leave;
        logic              emit;

        b     = {8'd0, r_buf} | ({8'd0, i_in.raw_byte} << r_fill);
        f     = {2'd0, r_fill} + 5'd8;
        pos   = r_pos;
        pend  = r_pend;
        pfail = r_pfail;
        dc    = r_dcnt;
        h0    = r_h0;
        h1    = r_h1;
        hc    = r_hcnt;
        dec   = 8'd0;
        leave = 8'd0;
        emit  = 1'b0;

        // At most one data byte and two parity bits are taken per request.
        for (int k = 0; k < 3; k++) begin
            if (!pos && f >= 5'd8) begin
                dec = b[7:0];
                b   = b >> 8;
                f   = f - 5'd8;
                pos = 1'b1;
                if (dc != '0) begin
                    pfail = pfail | pend;
                end
                pend = ^dec;
                if (dc < DCNT_W'(MAX_COUNT + 2)) begin
                    dc = dc + DCNT_W'(1);
                end
                if (hc == 2'd2) begin
                    leave = h0;
                    h0    = h1;
                    h1    = dec;
                    emit  = 1'b1;
                end else if (hc == 2'd0) begin
                    h0 = dec;
                    hc = 2'd1;
                end else begin
                    h1 = dec;
                    hc = 2'd2;
                end
            end else if (pos && f >= 5'd1) begin
                pend = pend ^ b[0] ^ 1'b1;
                b    = b >> 1;
                f    = f - 5'd1;
                pos  = 1'b0;
            end
        end

        o_q_entry.has_byte   = emit;
        o_q_entry.data       = leave;
        o_q_entry.frame_end  = i_in.frame_end;
        o_q_entry.parity_bad = pfail;
        o_q_entry.too_few    = dc < DCNT_W'(MIN_DECODED);
        o_q_entry.crc_rx     = {h1, h0};
        o_q_entry.pcount     = payload_count_of(dc);
        o_q_push             = accept && (emit || i_in.frame_end);

        if (i_in.frame_end) begin
            n_buf   = 8'd0;
            n_fill  = 3'd0;
            n_pos   = 1'b0;
            n_h0    = 8'd0;
            n_h1    = 8'd0;
            n_hcnt  = 2'd0;
            n_pend  = 1'b0;
            n_pfail = 1'b0;
            n_dcnt  = '0;
        end else begin
            n_buf   = b[7:0];
            n_fill  = f[2:0];
            n_pos   = pos;
            n_h0    = h0;
            n_h1    = h1;
            n_hcnt  = hc;
            n_pend  = pend;
            n_pfail = pfail;
            n_dcnt  = dc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= 8'd0;
            r_fill  <= 3'd0;
            r_pos   <= 1'b0;
            r_h0    <= 8'd0;
            r_h1    <= 8'd0;
            r_hcnt  <= 2'd0;
            r_pend  <= 1'b0;
            r_pfail <= 1'b0;
            r_dcnt  <= '0;
        end else if (accept) begin
            r_buf   <= n_buf;
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_h0    <= n_h0;
            r_h1    <= n_h1;
            r_hcnt  <= n_hcnt;
            r_pend  <= n_pend;
            r_pfail <= n_pfail;
            r_dcnt  <= n_dcnt;
        end
    end

endmodule

>>> hdl/t1rx_fifo.sv
// Short queue of front-end entries between the deframer and the result emitter.
module t1rx_fifo
    import t1rx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_head_valid
);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;

    assign o_ready      = r_count < QCNT_W'(QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> hdl/t1rx_back.sv
// Back end: running CRC_B over released bytes, status verdict and output register.
module t1rx_back
    import t1rx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_head_valid,
    output logic        o_pop,
    t1rx_out_if.source  o_out
);

    logic        r_phase,  n_phase;
    logic [15:0] r_crc,    n_crc;
    logic        r_ovalid, n_ovalid;
    t_kind       r_kind,   n_kind;
    logic [7:0]  r_data,   n_data;
    t_status     r_status, n_status;
    logic [7:0]  r_count,  n_count;
    logic        r_last,   n_last;

    logic    load;
    logic    fire;
    logic    byte_turn;
    t_status verdict;

    assign load      = !r_ovalid || o_out.ready;
    assign fire      = i_head_valid && load;
    assign byte_turn = i_head.has_byte && !r_phase;

    always_comb begin
        if (i_head.parity_bad) begin
            verdict = ST_PARITY;
        end else if (i_head.too_few) begin
            verdict = ST_SHORT;
        end else if (~r_crc == i_head.crc_rx) begin
            verdict = ST_OK;
        end else begin
            verdict = ST_CRC;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_ovalid = o_out.ready ? 1'b0 : r_ovalid;
        n_kind   = r_kind;
        n_data   = r_data;
        n_status = r_status;
        n_count  = r_count;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (fire) begin
            n_ovalid = 1'b1;
            n_count  = i_head.pcount;
            if (byte_turn) begin
                // A payload byte; when the same request ends the frame, the
                // entry stays at the head for its status item.
                n_kind   = KIND_DATA;
                n_data   = i_head.data;
                n_status = ST_OK;
                n_last   = !i_head.frame_end;
                n_crc    = crc_b_feed(r_crc, i_head.data);
                n_phase  = i_head.frame_end;
                o_pop    = !i_head.frame_end;
            end else begin
                n_kind   = KIND_STATUS;
                n_data   = 8'd0;
                n_status = verdict;
                n_last   = 1'b1;
                n_crc    = CRC_PRESET;
                n_phase  = 1'b0;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            r_crc    <= CRC_PRESET;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_status <= n_status;
        r_count  <= n_count;
        r_last   <= n_last;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.item_kind     = r_kind;
    assign o_out.data_byte     = r_data;
    assign o_out.frame_status  = r_status;
    assign o_out.payload_count = r_count;
    assign o_out.last_of_run   = r_last;

endmodule

>>> hdl/t1rx_checker.sv
// Port-level checker for the receive deframer, bound to the top level.
`include "assert_macros.svh"

module t1rx_checker
    import t1rx_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_item_kind,
    input logic [7:0] i_data_byte,
    input logic [1:0] i_frame_status,
    input logic [7:0] i_payload_count,
    input logic       i_last_of_run
);

    logic r_frame_start;
    logic out_accept;

    assign out_accept = i_out_valid && i_out_ready;

    // Set until the first result of a frame has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= 1'b1;
        end else if (out_accept) begin
            r_frame_start <= (i_item_kind == KIND_STATUS);
        end
    end

    `T1_ASSERT(a_stall_hold, ((i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_item_kind) && $stable(i_data_byte) && $stable(i_frame_status) && $stable(i_payload_count))), "result changed while stalled")
    `T1_ASSERT_IMPL(a_status_fields, i_out_valid && i_item_kind == KIND_STATUS, i_data_byte == 8'd0 && i_last_of_run, "status item carries data or is not last")
    `T1_ASSERT_IMPL(a_data_fields, i_out_valid && i_item_kind == KIND_DATA, i_frame_status == ST_OK && i_payload_count != 8'd0, "payload item has status or zero count")
    `T1_ASSERT_IMPL(a_first_count, i_out_valid && r_frame_start && i_item_kind == KIND_DATA, i_payload_count == 8'd1, "first payload byte of a frame not counted as one")

endmodule

bind type1_tag_rx_deframe_crc_check_unit t1rx_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_item_kind     (o_out.item_kind),
    .i_data_byte     (o_out.data_byte),
    .i_frame_status  (o_out.frame_status),
    .i_payload_count (o_out.payload_count),
    .i_last_of_run   (o_out.last_of_run)
);

>>> tb/tb_type1_tag_rx_deframe_crc_check_unit.sv
// Self-checking testbench for the tag receive deframer with parity and CRC_B check.
`timescale 1ns / 100ps

module tb_type1_tag_rx_deframe_crc_check_unit;
    import t1rx_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_status     status;
        logic [7:0]  count;
        logic        is_last;
    } t_rx_item;

    typedef enum int {
        FLT_NONE,
        FLT_PARITY,
        FLT_LAST_PARITY,
        FLT_CRC_LO,
        FLT_CRC_HI,
        FLT_TRUNCATE
    } t_fault;

    typedef struct {
        bit          framed;
        logic [7:0]  first_val;
        int          len;
        t_fault      fault;
        bit          typed;
        t_status     want_status;
        logic [7:0]  want_count;
    } t_plan_row;

    localparam int N_ROWS       = 19;
    localparam int RANDOM_BYTES = 550;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    // Raw rows repeat first_val len times; framed rows carry len payload bytes
    // counting up from first_val, followed by their CRC_B.
    t_plan_row plan [N_ROWS] = '{
        '{1'b0, 8'h00,   1, FLT_NONE,        1'b1, ST_SHORT,  8'd0},
        '{1'b0, 8'hFF,   1, FLT_NONE,        1'b1, ST_SHORT,  8'd0},
        '{1'b0, 8'h00,   3, FLT_NONE,        1'b1, ST_PARITY, 8'd0},
        '{1'b0, 8'hFF,   3, FLT_NONE,        1'b1, ST_SHORT,  8'd0},
        '{1'b0, 8'hA5,  20, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b0, 8'hFF,  40, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h00,   0, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h00,   1, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'hFF,   2, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h00,   5, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'hF0,   8, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h80,   3, FLT_NONE,        1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h3C,   6, FLT_PARITY,      1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h10,   1, FLT_PARITY,      1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h55,   4, FLT_LAST_PARITY, 1'b0, ST_OK,     8'd0},
        '{1'b1, 8'hAA,   4, FLT_CRC_LO,      1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h01,   4, FLT_CRC_HI,      1'b0, ST_OK,     8'd0},
        '{1'b1, 8'hFE,   7, FLT_TRUNCATE,    1'b0, ST_OK,     8'd0},
        '{1'b1, 8'h00, 300, FLT_NONE,        1'b0, ST_OK,     8'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    t1rx_in_if  in_if ();
    t1rx_out_if out_if ();

    type1_tag_rx_deframe_crc_check_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Predicted deframer state.
    logic [15:0] pend_bits;
    int          pend_fill;
    bit          want_parity;
    logic [7:0]  delay_line [2];
    int          delay_fill;
    bit          newest_bad;
    bit          frame_par_err;
    logic [15:0] crc_acc;
    int          n_decoded;

    t_rx_item    step_items [$];
    t_rx_item    items_owed [$];
    logic [7:0]  raw_burst [$];

    int errors       = 0;
    int raw_sent     = 0;
    int frames_sent  = 0;
    int checked      = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    bit quiet        = 1'b0;
    bit hold_asked   = 1'b0;
    int hold_left    = 0;
    bit held_once    = 1'b0;

    function automatic logic [15:0] crc_b_next(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        c = acc ^ {8'h00, d};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] payload_now();
        int p;
        p = (n_decoded >= 2) ? n_decoded - 2 : 0;
        return (p > 255) ? 8'hFF : p[7:0];
    endfunction

    function automatic t_rx_item make_item(t_kind k, logic [7:0] d, t_status s,
                                           logic [7:0] c, logic l);
        t_rx_item it;
        it.kind    = k;
        it.data    = d;
        it.status  = s;
        it.count   = c;
        it.is_last = l;
        return it;
    endfunction

    task automatic clear_model();
        pend_bits     = '0;
        pend_fill     = 0;
        want_parity   = 1'b0;
        delay_line[0] = '0;
        delay_line[1] = '0;
        delay_fill    = 0;
        newest_bad    = 1'b0;
        frame_par_err = 1'b0;
        crc_acc       = CRC_PRESET;
        n_decoded     = 0;
    endtask

    // Works out the result items one accepted raw byte causes.
    task automatic predict_raw(input logic [7:0] raw, input logic is_end);
        logic [31:0] wide;
        logic [7:0]  dec;
        logic [7:0]  leaving;
        logic [15:0] crc_rx;
        t_status     st;
        step_items.delete();
        wide      = {16'h0000, pend_bits} | ({24'h000000, raw} << pend_fill);
        pend_bits = wide[15:0];
        pend_fill += 8;
        for (int k = 0; k < 3; k++) begin
            if (!want_parity && pend_fill >= 8) begin
                dec         = pend_bits[7:0];
                pend_bits   = pend_bits >> 8;
                pend_fill  -= 8;
                want_parity = 1'b1;
                // The previous byte's parity is only judged now.
                if (n_decoded >= 1) frame_par_err |= newest_bad;
                newest_bad = ^dec;
                if (n_decoded < MAX_COUNT + 2) n_decoded++;
                if (delay_fill >= 2) begin
                    leaving       = delay_line[0];
                    delay_line[0] = delay_line[1];
                    delay_line[1] = dec;
                    crc_acc       = crc_b_next(crc_acc, leaving);
                    step_items.push_back(make_item(KIND_DATA, leaving, ST_OK,
                                                   payload_now(), 1'b0));
                end else begin
                    delay_line[delay_fill] = dec;
                    delay_fill++;
                end
            end else if (want_parity && pend_fill >= 1) begin
                newest_bad  = newest_bad ^ pend_bits[0] ^ 1'b1;
                pend_bits   = pend_bits >> 1;
                pend_fill  -= 1;
                want_parity = 1'b0;
            end
        end
        if (is_end) begin
            crc_rx = ~crc_acc;
            if (frame_par_err)
                st = ST_PARITY;
            else if (n_decoded < MIN_DECODED)
                st = ST_SHORT;
            else if (crc_rx[7:0] == delay_line[0] && crc_rx[15:8] == delay_line[1])
                st = ST_OK;
            else
                st = ST_CRC;
            step_items.push_back(make_item(KIND_STATUS, 8'h00, st, payload_now(), 1'b0));
            clear_model();
        end
        if (step_items.size() > 0) step_items[step_items.size() - 1].is_last = 1'b1;
    endtask

    // Encodes payload plus CRC_B as 9-bit chunks with odd parity, LSB first.
    task automatic build_frame(input int len, input logic [7:0] first_val,
                               input bit rand_content, input t_fault fault);
        logic [7:0]  dec [$];
        logic [15:0] acc;
        logic [7:0]  v;
        bit          bits [$];
        int          flip_at;
        int          cut;
        acc = CRC_PRESET;
        for (int i = 0; i < len; i++) begin
            v = rand_content ? 8'($urandom_range(255)) : 8'(first_val + i);
            dec.push_back(v);
            acc = crc_b_next(acc, v);
        end
        acc = ~acc;
        dec.push_back(acc[7:0]);
        dec.push_back(acc[15:8]);
        flip_at = -1;
        case (fault)
            FLT_CRC_LO:      dec[len]     ^= 8'(1 << $urandom_range(7));
            FLT_CRC_HI:      dec[len + 1] ^= 8'(1 << $urandom_range(7));
            FLT_PARITY:      flip_at = $urandom_range(dec.size() - 2);
            FLT_LAST_PARITY: flip_at = dec.size() - 1;
            default: ;
        endcase
        foreach (dec[i]) begin
            for (int b = 0; b < 8; b++) bits.push_back(dec[i][b]);
            bits.push_back((~^dec[i]) ^ (i == flip_at));
        end
        while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(1)));
        raw_burst.delete();
        for (int i = 0; i < bits.size(); i += 8) begin
            for (int b = 0; b < 8; b++) v[b] = bits[i + b];
            raw_burst.push_back(v);
        end
        if (fault == FLT_TRUNCATE && raw_burst.size() > 1) begin
            cut = $urandom_range(raw_burst.size() - 1, 1);
            repeat (cut) void'(raw_burst.pop_back());
        end
    endtask

    task automatic build_noise(input int len, input logic [7:0] fill, input bit rand_content);
        raw_burst.delete();
        repeat (len) raw_burst.push_back(rand_content ? 8'($urandom_range(255)) : fill);
    endtask

    // Mostly no pause, sometimes a short one, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 75) return 0;
        if (r < 96) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic offer(input logic [7:0] b, input logic is_end, input bit typed,
                         input t_rx_item typed_item);
        int gap;
        gap = pick_pause();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.raw_byte  <= b;
        in_if.frame_end <= is_end;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        raw_sent++;
        predict_raw(b, is_end);
        if (typed)
            items_owed.push_back(typed_item);
        else
            foreach (step_items[i]) items_owed.push_back(step_items[i]);
    endtask

    // Sends raw_burst as one frame; a typed item, if given, replaces the
    // prediction for the frame's last byte.
    task automatic send_burst(input bit typed, input t_rx_item typed_item);
        int n;
        n = raw_burst.size();
        for (int i = 0; i < n; i++)
            offer(raw_burst[i], i == n - 1, typed && (i == n - 1), typed_item);
        frames_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (items_owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_fault(input string what);
        errors++;
        if (errors <= 10) $display("ERROR at %0t: %s", $realtime, what);
    endtask

    task automatic check_item();
        t_rx_item got;
        t_rx_item want;
        got = make_item(t_kind'(out_if.item_kind), out_if.data_byte,
                        t_status'(out_if.frame_status), out_if.payload_count,
                        out_if.last_of_run);
        checked++;
        if (got.kind == KIND_STATUS) status_seen[got.status]++;
        if (items_owed.size() == 0) begin
            report_fault($sformatf("unexpected result kind=%0d data=%02h status=%0d count=%0d",
                                   got.kind, got.data, got.status, got.count));
        end else begin
            want = items_owed.pop_front();
            if (got !== want)
                report_fault($sformatf({"expected kind=%0d data=%02h status=%0d count=%0d ",
                                        "last=%0d, got kind=%0d data=%02h status=%0d ",
                                        "count=%0d last=%0d"},
                                       want.kind, want.data, want.status, want.count,
                                       want.is_last, got.kind, got.data, got.status,
                                       got.count, got.is_last));
        end
    endtask

    // Result side: checks each accepted result item and drives ready.
    initial begin : result_side
        int  stall_left;
        int  r;
        logic rdy;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) check_item();
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_asked) begin
                // Long hold-off so the internal queue fills and input stalls.
                hold_asked = 1'b0;
                held_once  = 1'b1;
                hold_left  = LONG_HOLD - 1;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                r = $urandom_range(99);
                if (!quiet && r < 25)
                    stall_left = (r < 3) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            end
            out_if.ready <= rdy;
        end
    end

    initial begin : stimulus
        int        base;
        int        r;
        int        len;
        t_fault    flt;
        t_rx_item  typed_item;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.raw_byte  <= 8'h00;
        in_if.frame_end <= 1'b0;
        clear_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].framed)
                build_frame(plan[i].len, plan[i].first_val, 1'b0, plan[i].fault);
            else
                build_noise(plan[i].len, plan[i].first_val, 1'b0);
            typed_item = make_item(KIND_STATUS, 8'h00, plan[i].want_status,
                                   plan[i].want_count, 1'b1);
            send_burst(plan[i].typed, typed_item);
        end
        wait_drained();

        base = raw_sent;
        while (raw_sent - base < RANDOM_BYTES) begin
            quiet = ($urandom_range(9) == 0);
            r = $urandom_range(99);
            if (r < 75) begin
                r = $urandom_range(99);
                if (r < 85)
                    len = $urandom_range(12);
                else if (r < 99)
                    len = $urandom_range(40, 13);
                else
                    len = $urandom_range(300, 250);
                r = $urandom_range(99);
                if (r < 55)      flt = FLT_NONE;
                else if (r < 70) flt = FLT_PARITY;
                else if (r < 78) flt = FLT_LAST_PARITY;
                else if (r < 86) flt = FLT_CRC_LO;
                else if (r < 94) flt = FLT_CRC_HI;
                else             flt = FLT_TRUNCATE;
                build_frame(len, 8'h00, 1'b1, flt);
            end else begin
                build_noise($urandom_range(16, 1), 8'h00, 1'b1);
            end
            if (!held_once && raw_sent - base >= 300) hold_asked = 1'b1;
            send_burst(1'b0, typed_item);
            if (frames_sent % 25 == 0) wait_drained();
        end
        quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        errors += items_owed.size();

        $display("Sent %0d raw bytes in %0d frames, checked %0d result items.",
                 raw_sent, frames_sent, checked);
        $display("Frame outcomes seen: ok %0d, parity error %0d, crc mismatch %0d, short %0d.",
                 status_seen[ST_OK], status_seen[ST_PARITY], status_seen[ST_CRC],
                 status_seen[ST_SHORT]);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Timeout: %0d result items still outstanding.", items_owed.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/t1rx_pkg.sv
hdl/t1rx_ifs.sv
hdl/t1rx_front.sv
hdl/t1rx_fifo.sv
hdl/t1rx_back.sv
hdl/type1_tag_rx_deframe_crc_check_unit.sv
hdl/t1rx_checker.sv
tb/tb_type1_tag_rx_deframe_crc_check_unit.sv
